// ===== rtl/i2cms_pkg.sv =====
package i2cms_pkg;

  // largest number of data bytes a transaction may move
  localparam int unsigned MAX_BYTES = 256;

  localparam int unsigned CountW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_DIR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_COUNT = 2'd2;

  // item modes
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  // controller status codes, low three bits masked
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_START = 8'h08;
  localparam logic [7:0] ST_RESTART = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
  localparam logic [7:0] ST_SLAVE_LO = 8'h60;
  localparam logic [7:0] ST_SLAVE_HI = 8'hC8;
  localparam logic [7:0] ST_IDLE = 8'hF8;

  // start and auto-ack actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SET = 2'd1;
  localparam logic [1:0] ACT_CLR = 2'd2;

  // error numbers
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_NOT_IDLE = 3'd1;
  localparam logic [2:0] ERR_BUS = 3'd2;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        start_action;
    logic [1:0]        aa_action;
    logic              set_stop;
    logic              load_data;
    logic [7:0]        data_out;
    logic              tx_taken;
    logic              rx_valid;
    logic [7:0]        rx_data;
    logic              ack_seen;
    logic              done_res;
    logic [2:0]        error;
    logic [CountW-1:0] bytes_done;
  } out_item_t;

  typedef struct packed {
    logic [6:0]        target_addr;
    logic              write_dir;
    logic [CountW-1:0] byte_count;
  } cfg_t;

endpackage

// ===== rtl/i2cms_cfg_regs.sv =====
module i2cms_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [i2cms_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [i2cms_pkg::CfgDataW-1:0] cfg_data,
  output i2cms_pkg::cfg_t               cfg
);

  i2cms_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_addr <= 7'd0;
      cfg_r.write_dir <= 1'b1;
      cfg_r.byte_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2cms_pkg::CFG_TARGET_ADDR: cfg_r.target_addr <= cfg_data[6:0];
        i2cms_pkg::CFG_WRITE_DIR:   cfg_r.write_dir <= cfg_data[0];
        i2cms_pkg::CFG_BYTE_COUNT:  cfg_r.byte_count <= cfg_data[i2cms_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/i2cms_in_stage.sv =====
module i2cms_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cms_pkg::in_item_t in_item,
  output logic                item_valid,
  output i2cms_pkg::in_item_t item,
  input  logic                take
);

  logic                valid_r;
  i2cms_pkg::in_item_t item_r;

  // holds a beat while the result register is still full
  assign in_stall = valid_r && !take;
  assign item_valid = valid_r;
  assign item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/i2cms_seq.sv =====
module i2cms_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  i2cms_pkg::in_item_t  item,
  input  i2cms_pkg::cfg_t      cfg,
  output i2cms_pkg::out_item_t result
);

  localparam int unsigned CW = i2cms_pkg::CountW;

  logic          active_r, active_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ack_r, ack_nxt;

  logic [7:0]    code;
  logic [CW-1:0] eff_count;
  logic [CW-1:0] rem;
  logic [CW-1:0] rem_m1;
  logic [CW-1:0] idx_inc;

  assign code = item.status_code & 8'hF8;
  assign eff_count = ({8'd0, cfg.byte_count} > 17'(i2cms_pkg::MAX_BYTES)) ?
                     CW'(i2cms_pkg::MAX_BYTES) : cfg.byte_count;
  assign rem = (eff_count > idx_r) ? eff_count - idx_r : '0;
  assign rem_m1 = rem - 1'b1;
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    active_nxt = active_r;
    idx_nxt = idx_r;
    ack_nxt = ack_r;
    result = '0;

    if (item.mode == i2cms_pkg::MODE_BEGIN) begin
      active_nxt = 1'b0;
      idx_nxt = '0;
      ack_nxt = 1'b0;
      if (code != i2cms_pkg::ST_IDLE) begin
        result.done_res = 1'b1;
        result.error = i2cms_pkg::ERR_NOT_IDLE;
      end else begin
        active_nxt = 1'b1;
        // index restarts at zero, so the whole count remains
        result.aa_action = (eff_count > CW'(1) && !cfg.write_dir) ?
                           i2cms_pkg::ACT_SET : i2cms_pkg::ACT_CLR;
        result.start_action = i2cms_pkg::ACT_SET;
      end
    end else if (active_r) begin
      case (code)
        i2cms_pkg::ST_BUS_ERROR: begin
          result.done_res = 1'b1;
          result.error = i2cms_pkg::ERR_BUS;
          active_nxt = 1'b0;
        end
        i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
          result.start_action = i2cms_pkg::ACT_CLR;
          result.load_data = 1'b1;
          result.data_out = {cfg.target_addr, !cfg.write_dir};
        end
        i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_SLA_W_NACK,
        i2cms_pkg::ST_SLA_R_ACK, i2cms_pkg::ST_SLA_R_NACK: begin
          ack_nxt = (code == i2cms_pkg::ST_SLA_W_ACK) || (code == i2cms_pkg::ST_SLA_R_ACK);
          if (rem != '0 && ack_nxt) begin
            if (cfg.write_dir) begin
              result.load_data = 1'b1;
              result.data_out = item.tx_byte;
              result.tx_taken = 1'b1;
              idx_nxt = idx_inc;
            end else if (rem == CW'(1)) begin
              result.aa_action = i2cms_pkg::ACT_CLR;
            end
          end else begin
            result.set_stop = 1'b1;
          end
        end
        i2cms_pkg::ST_DATA_W_ACK, i2cms_pkg::ST_DATA_W_NACK: begin
          ack_nxt = (code == i2cms_pkg::ST_DATA_W_ACK);
          if (rem != '0 && ack_nxt) begin
            result.load_data = 1'b1;
            result.data_out = item.tx_byte;
            result.tx_taken = 1'b1;
            idx_nxt = idx_inc;
          end else begin
            result.set_stop = 1'b1;
          end
        end
        i2cms_pkg::ST_DATA_R_ACK, i2cms_pkg::ST_DATA_R_NACK: begin
          ack_nxt = (code == i2cms_pkg::ST_DATA_R_ACK);
          if (rem == '0) begin
            // byte beyond the count is dropped
            result.set_stop = 1'b1;
          end else begin
            result.rx_valid = 1'b1;
            result.rx_data = item.rx_byte;
            idx_nxt = idx_inc;
            if (rem_m1 == '0) begin
              result.set_stop = 1'b1;
            end else if (rem_m1 == CW'(1)) begin
              result.aa_action = i2cms_pkg::ACT_CLR;
            end
          end
        end
        i2cms_pkg::ST_IDLE: begin
          result.done_res = 1'b1;
          active_nxt = 1'b0;
        end
        default: begin
          if (code == i2cms_pkg::ST_ARB_LOST ||
              (code >= i2cms_pkg::ST_SLAVE_LO && code <= i2cms_pkg::ST_SLAVE_HI)) begin
            result.error = i2cms_pkg::ERR_UNSUPPORTED;
          end else begin
            result.error = i2cms_pkg::ERR_UNKNOWN;
          end
          result.done_res = 1'b1;
          active_nxt = 1'b0;
        end
      endcase
    end

    result.ack_seen = ack_nxt;
    result.bytes_done = idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r <= '0;
      ack_r <= 1'b0;
    end else if (take) begin
      active_r <= active_nxt;
      idx_r <= idx_nxt;
      ack_r <= ack_nxt;
    end
  end

endmodule

// ===== rtl/i2cms_out_stage.sv =====
module i2cms_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 src_valid,
  input  i2cms_pkg::out_item_t result,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_item_t out_item
);

  logic                 valid_r;
  i2cms_pkg::out_item_t item_r;

  // register is free when empty or its beat leaves this cycle
  assign take = src_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= result;
    end
  end

endmodule

// ===== rtl/i2c_master_status_sequencer_top.sv =====
// I2C master sequencer answering byte-oriented controller status codes.
// Input channel (in_valid / in_stall / in_item): a begin beat (mode 0) checks
// for bus idle and requests a start; an event beat (mode 1) answers one
// status code read after an interrupt. Each input beat yields exactly one
// result beat on out_valid / out_stall / out_item, in order.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
// slave address, direction and byte count; cfg_ready is always high and
// writes belong between transactions while the block is empty.
// An input beat passes through the input register, the status decode and
// the result register. One beat per cycle is sustained while the receiver
// does not stall; the decode reads and updates the transaction state as each beat is taken.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; in_stall rises only when both are full.
// Synchronous reset clears both registers, the transaction state and the
// configuration (address 0, write direction, byte count 0).
module i2c_master_status_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  i2cms_pkg::in_item_t            in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output i2cms_pkg::out_item_t           out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2cms_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [i2cms_pkg::CfgDataW-1:0] cfg_data
);

  i2cms_pkg::cfg_t      cfg;
  i2cms_pkg::in_item_t  item;
  i2cms_pkg::out_item_t result;
  logic                 item_valid;
  logic                 take;

  i2cms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  i2cms_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  i2cms_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (item_valid),
    .result    (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TargetItems = 1600;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCycles = 6;

  // codes outside every defined status group
  localparam logic [7:0] ST_UNKNOWN_LO = 8'hD0;
  localparam logic [7:0] ST_UNKNOWN_HI = 8'hF0;
  localparam logic [7:0] LOW_BITS = 8'h07;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  i2cms_pkg::in_item_t            in_item = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  i2cms_pkg::out_item_t           out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [i2cms_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [i2cms_pkg::CfgDataW-1:0] cfg_data = '0;

  i2c_master_status_sequencer_top u_top (.*);

  // stimulus and expected answers
  i2cms_pkg::in_item_t  status_q[$];
  i2cms_pkg::out_item_t answer_q[$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  logic        in_fire = 1'b0;

  // sequencer state and register copy
  logic        seq_active = 1'b0;
  int unsigned seq_index = 0;
  logic        seq_ack = 1'b0;
  logic [6:0]  reg_addr = '0;
  logic        reg_write = 1'b1;
  logic [8:0]  reg_count = '0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic i2cms_pkg::out_item_t answer_status(i2cms_pkg::in_item_t it);
    i2cms_pkg::out_item_t r;
    logic [7:0]           code;
    int unsigned          lim;
    int unsigned          rem;
    r = '0;
    code = it.status_code & 8'hF8;
    lim = (reg_count > i2cms_pkg::MAX_BYTES) ? i2cms_pkg::MAX_BYTES : reg_count;
    if (it.mode == i2cms_pkg::MODE_BEGIN) begin
      // a begin always drops whatever was running
      seq_active = 1'b0;
      seq_index = 0;
      seq_ack = 1'b0;
      if (code != i2cms_pkg::ST_IDLE) begin
        r.done_res = 1'b1;
        r.error = i2cms_pkg::ERR_NOT_IDLE;
      end else begin
        seq_active = 1'b1;
        r.aa_action = (lim > 1 && !reg_write) ? i2cms_pkg::ACT_SET : i2cms_pkg::ACT_CLR;
        r.start_action = i2cms_pkg::ACT_SET;
      end
    end else if (seq_active) begin
      rem = (lim > seq_index) ? lim - seq_index : 0;
      case (code)
        i2cms_pkg::ST_BUS_ERROR: begin
          r.done_res = 1'b1;
          r.error = i2cms_pkg::ERR_BUS;
          seq_active = 1'b0;
        end
        i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
          r.start_action = i2cms_pkg::ACT_CLR;
          r.load_data = 1'b1;
          r.data_out = {reg_addr, !reg_write};
        end
        i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_SLA_W_NACK,
        i2cms_pkg::ST_SLA_R_ACK, i2cms_pkg::ST_SLA_R_NACK: begin
          seq_ack = (code == i2cms_pkg::ST_SLA_W_ACK || code == i2cms_pkg::ST_SLA_R_ACK);
          if (rem > 0 && seq_ack) begin
            if (reg_write) begin
              r.load_data = 1'b1;
              r.data_out = it.tx_byte;
              r.tx_taken = 1'b1;
              seq_index++;
            end else if (rem == 1) begin
              r.aa_action = i2cms_pkg::ACT_CLR;
            end
          end else begin
            r.set_stop = 1'b1;
          end
        end
        i2cms_pkg::ST_DATA_W_ACK, i2cms_pkg::ST_DATA_W_NACK: begin
          seq_ack = (code == i2cms_pkg::ST_DATA_W_ACK);
          if (rem > 0 && seq_ack) begin
            r.load_data = 1'b1;
            r.data_out = it.tx_byte;
            r.tx_taken = 1'b1;
            seq_index++;
          end else begin
            r.set_stop = 1'b1;
          end
        end
        i2cms_pkg::ST_DATA_R_ACK, i2cms_pkg::ST_DATA_R_NACK: begin
          seq_ack = (code == i2cms_pkg::ST_DATA_R_ACK);
          if (rem == 0) begin
            r.set_stop = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_data = it.rx_byte;
            seq_index++;
            rem--;
            // nack goes out before the last byte
            if (rem == 0) r.set_stop = 1'b1;
            else if (rem == 1) r.aa_action = i2cms_pkg::ACT_CLR;
          end
        end
        i2cms_pkg::ST_IDLE: begin
          r.done_res = 1'b1;
          seq_active = 1'b0;
        end
        default: begin
          if (code == i2cms_pkg::ST_ARB_LOST ||
              (code >= i2cms_pkg::ST_SLAVE_LO && code <= i2cms_pkg::ST_SLAVE_HI)) begin
            r.error = i2cms_pkg::ERR_UNSUPPORTED;
          end else begin
            r.error = i2cms_pkg::ERR_UNKNOWN;
          end
          r.done_res = 1'b1;
          seq_active = 1'b0;
        end
      endcase
    end
    r.ack_seen = seq_ack;
    r.bytes_done = seq_index[i2cms_pkg::CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  task automatic check_field(string field, logic [8:0] got, logic [8:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  task automatic check_answer(i2cms_pkg::out_item_t got, i2cms_pkg::out_item_t want);
    check_field("start_action", got.start_action, want.start_action);
    check_field("aa_action", got.aa_action, want.aa_action);
    check_field("set_stop", got.set_stop, want.set_stop);
    check_field("load_data", got.load_data, want.load_data);
    check_field("data_out", got.data_out, want.data_out);
    check_field("tx_taken", got.tx_taken, want.tx_taken);
    check_field("rx_valid", got.rx_valid, want.rx_valid);
    check_field("rx_data", got.rx_data, want.rx_data);
    check_field("ack_seen", got.ack_seen, want.ack_seen);
    check_field("done_res", got.done_res, want.done_res);
    check_field("error", got.error, want.error);
    check_field("bytes_done", got.bytes_done, want.bytes_done);
  endtask

  // monitor: results, register writes and accepted input beats
  always @(posedge clk) begin : monitor
    i2cms_pkg::out_item_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      cycle_cnt++;
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, '0);
        end else begin
          want = answer_q.pop_front();
          check_answer(out_item, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cms_pkg::CFG_TARGET_ADDR: reg_addr = cfg_data[6:0];
          i2cms_pkg::CFG_WRITE_DIR:   reg_write = cfg_data[0];
          i2cms_pkg::CFG_BYTE_COUNT:  reg_count = cfg_data[8:0];
          default: ;
        endcase
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        answer_q.push_back(answer_status(in_item));
        accepted_cnt++;
      end
      if (cycle_cnt > CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // driver: next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (status_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_item <= status_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // the controller ignores the low three status bits
  function automatic logic [7:0] with_low_bits(logic [7:0] code);
    return ($urandom_range(3) == 0) ? (code | 8'($urandom_range(7))) : code;
  endfunction

  task automatic push_item(logic mode, logic [7:0] code, logic [7:0] rxb, logic [7:0] txb);
    i2cms_pkg::in_item_t it;
    it.mode = mode;
    it.status_code = code;
    it.rx_byte = rxb;
    it.tx_byte = txb;
    status_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic push_event(logic [7:0] code);
    push_item(i2cms_pkg::MODE_EVENT, with_low_bits(code), rnd8(), rnd8());
  endtask

  // one transfer as the controller would report it, now and then broken
  task automatic queue_transfer(logic wr, int unsigned nbytes);
    int unsigned n;
    logic        acked;
    n = nbytes;
    if ($urandom_range(99) < 5) n = n + 1 + $urandom_range(2);
    push_item(i2cms_pkg::MODE_BEGIN,
              ($urandom_range(99) < 5) ? rnd8() : with_low_bits(i2cms_pkg::ST_IDLE),
              rnd8(), rnd8());
    push_event(($urandom_range(9) == 0) ? i2cms_pkg::ST_RESTART : i2cms_pkg::ST_START);
    acked = ($urandom_range(99) < 92);
    if (wr) push_event(acked ? i2cms_pkg::ST_SLA_W_ACK : i2cms_pkg::ST_SLA_W_NACK);
    else push_event(acked ? i2cms_pkg::ST_SLA_R_ACK : i2cms_pkg::ST_SLA_R_NACK);
    for (int unsigned i = 0; acked && i < n; i++) begin
      if (wr) begin
        acked = ($urandom_range(99) < 95);
        push_event(acked ? i2cms_pkg::ST_DATA_W_ACK : i2cms_pkg::ST_DATA_W_NACK);
      end else begin
        push_event(((i + 1 >= n) ^ ($urandom_range(99) < 5)) ?
                   i2cms_pkg::ST_DATA_R_NACK : i2cms_pkg::ST_DATA_R_ACK);
      end
    end
    if ($urandom_range(99) < 85) push_event(i2cms_pkg::ST_IDLE);
    else push_event(rnd8());
  endtask

  task automatic program_regs(logic [6:0] addr, logic wr, logic [8:0] cnt);
    logic [i2cms_pkg::CfgIdxW-1:0]  regs[3];
    logic [i2cms_pkg::CfgDataW-1:0] vals[3];
    regs = '{i2cms_pkg::CFG_TARGET_ADDR, i2cms_pkg::CFG_WRITE_DIR, i2cms_pkg::CFG_BYTE_COUNT};
    vals = '{i2cms_pkg::CfgDataW'(addr), i2cms_pkg::CfgDataW'(wr), i2cms_pkg::CfgDataW'(cnt)};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (accepted_cnt != queued_cnt || answer_q.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int unsigned p;
    int unsigned lim;
    int unsigned phase_start;
    logic [6:0]  addr;
    logic        wr;
    logic [8:0]  cnt;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_regs(7'h7F, 1'b1, 9'd1);
    @(posedge clk);
    // nothing running
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_START, 8'h00, 8'h00);
    // bus not idle
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_BUS_ERROR, 8'hFF, 8'hFF);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'hFF);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_START, 8'hFF, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_SLA_W_ACK, 8'h00, 8'hFF);
    // count reached
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_DATA_W_ACK, 8'hFF, 8'h00);
    // byte past the count
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_DATA_R_ACK, 8'hA5, 8'h5A);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_IDLE | LOW_BITS, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    // restart while running
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE | LOW_BITS, 8'hFF, 8'hFF);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_RESTART, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_SLA_R_NACK, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_DATA_W_NACK, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_DATA_R_NACK, 8'hFF, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_BUS_ERROR, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_ARB_LOST, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_SLAVE_LO, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, i2cms_pkg::ST_SLAVE_HI, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, ST_UNKNOWN_LO, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_BEGIN, i2cms_pkg::ST_IDLE, 8'h00, 8'h00);
    push_item(i2cms_pkg::MODE_EVENT, ST_UNKNOWN_HI, 8'h00, 8'h00);
    wait_drained();

    p = 0;
    while (queued_cnt < TargetItems) begin
      case (p)
        0: begin addr = 7'h00; wr = 1'b0; cnt = 9'd0; end
        1: begin addr = 7'h7F; wr = 1'b1; cnt = 9'd256; end
        2: begin addr = 7'h55; wr = 1'b0; cnt = 9'h1FF; end
        3: begin addr = 7'h2A; wr = 1'b0; cnt = 9'd1; end
        4: begin addr = 7'h7F; wr = 1'b0; cnt = 9'd2; end
        default: begin
          addr = 7'($urandom);
          wr = 1'($urandom);
          cnt = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 257)) : 9'($urandom_range(6));
        end
      endcase
      program_regs(addr, wr, cnt);
      @(posedge clk);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 70; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 70; end
        default: begin in_idle_pct = 33; out_stall_pct = 33; end
      endcase
      lim = (cnt > i2cms_pkg::MAX_BYTES) ? i2cms_pkg::MAX_BYTES : cnt;
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < 80) begin
        if ($urandom_range(99) < 15) begin
          repeat (1 + $urandom_range(3))
            push_item(1'($urandom), rnd8(), rnd8(), rnd8());
        end else begin
          queue_transfer(wr ^ ($urandom_range(19) == 0), lim);
        end
      end
      wait_drained();
      p++;
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
